### sv/dns_query_fixed_answer_responder_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef DNS_QUERY_FIXED_ANSWER_RESPONDER_UNIT_DEFINES_SVH
`define DNS_QUERY_FIXED_ANSWER_RESPONDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DQFAR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dqfar check failed");

// Next-cycle implication, disabled in reset.
`define DQFAR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dqfar check failed");

`endif

### sv/dqfar_pkg.sv
package dqfar_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] in_byte;
        logic       in_last;
    } t_req_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] status;
    } t_rsp_word;

    typedef struct packed {
        logic      push;
        t_rsp_word word;
    } t_rsp_push;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_PULL    = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TRUNC    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic CFG_TTL  = 1'b0;
    localparam logic CFG_ADDR = 1'b1;

    localparam logic [31:0] TTL_RESET  = 32'd3600;
    localparam logic [31:0] ADDR_RESET = (32'd8 << 24) | (32'd8 << 16) | (32'd8 << 8) | 32'd8;

endpackage

### sv/dqfar_req_if.sv
interface dqfar_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output operation, output in_byte, output in_last,
                    input ready);
    modport sink   (input valid, input operation, input in_byte, input in_last,
                    output ready);
endinterface

### sv/dqfar_rsp_if.sv
interface dqfar_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output out_last, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input status,
                    output ready);
endinterface

### sv/dqfar_core.sv
module dqfar_core #(
    parameter int STORE_DEPTH = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  dqfar_pkg::t_req_word  i_word,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output dqfar_pkg::t_rsp_push  o_res
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(STORE_DEPTH);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_QTAIL  = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_ANAME  = 3'd4;
    localparam logic [2:0] PH_ATAIL  = 3'd5;

    localparam logic [3:0] HDR_LAST  = 4'd11;
    localparam logic [3:0] QTAIL_LEN = 4'd4;
    localparam logic [3:0] TTL_FIRST = 4'd4;
    localparam logic [3:0] RDL_HI    = 4'd8;
    localparam logic [3:0] RDL_LO    = 4'd9;
    localparam logic [3:0] ADDR_BASE = 4'd10;
    localparam logic [3:0] TAIL_LAST = 4'd13;
    localparam logic [7:0] RDLEN_LO  = 8'd4;
    localparam logic [7:0] RCODE_NI  = 8'd4;

    logic [2:0]    r_phase,  n_phase;
    logic [3:0]    r_hp,     n_hp;
    logic [3:0]    r_opcode, n_opcode;
    logic [15:0]   r_qc,     n_qc;
    logic [15:0]   r_qd,     n_qd;
    logic [3:0]    r_tc,     n_tc;
    logic [FW-1:0] r_fill,   n_fill;
    logic [FW-1:0] r_rp,     n_rp;
    logic [31:0]   r_ttl;
    logic [31:0]   r_addr;
    logic [7:0]    r_rd;
    logic [7:0]    r_mem [STORE_DEPTH];

    logic          restart;
    logic [2:0]    e_phase;
    logic [3:0]    e_hp;
    logic [3:0]    e_opcode;
    logic [15:0]   e_qc;
    logic [15:0]   e_qd;
    logic [3:0]    e_tc;
    logic [FW-1:0] e_fill;
    logic [15:0]   qc_hdr;
    logic [15:0]   qd_after;
    logic [2:0]    ph_after;
    logic [3:0]    tc_inc;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [7:0]    b;

    function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = w[31:24];
            2'd1:    v = w[23:16];
            2'd2:    v = w[15:8];
            default: v = w[7:0];
        endcase
        return v;
    endfunction

    always_comb begin
        b        = i_word.in_byte;
        restart  = (r_phase >= PH_ANAME);
        e_phase  = restart ? PH_HEADER : r_phase;
        e_hp     = restart ? 4'd0 : r_hp;
        e_opcode = restart ? 4'd0 : r_opcode;
        e_qc     = restart ? 16'd0 : r_qc;
        e_qd     = restart ? 16'd0 : r_qd;
        e_tc     = restart ? 4'd0 : r_tc;
        e_fill   = restart ? '0 : r_fill;
        qc_hdr   = e_qc;
        qd_after = e_qd;
        ph_after = e_phase;
        tc_inc   = e_tc + 4'd1;

        n_phase  = r_phase;
        n_hp     = r_hp;
        n_opcode = r_opcode;
        n_qc     = r_qc;
        n_qd     = r_qd;
        n_tc     = r_tc;
        n_fill   = r_fill;
        n_rp     = r_rp;
        w_we     = 1'b0;
        w_waddr  = e_fill[AW-1:0];
        o_res    = '0;

        if (i_accept && i_word.operation == dqfar_pkg::OP_REQUEST) begin
            n_phase  = e_phase;
            n_hp     = e_hp;
            n_opcode = e_opcode;
            n_qc     = e_qc;
            n_qd     = e_qd;
            n_tc     = e_tc;
            n_fill   = e_fill;
            n_rp     = restart ? '0 : r_rp;
            unique case (e_phase)
                PH_HEADER: begin
                    o_res.push = 1'b1;
                    case (e_hp) inside
                        4'd0, 4'd1: o_res.word.out_byte = b;
                        4'd2: begin
                            o_res.word.out_byte = 8'h80 | (b & 8'h79);
                            n_opcode = b[6:3];
                        end
                        4'd3: o_res.word.out_byte = (e_opcode != 4'd0) ? RCODE_NI : 8'd0;
                        4'd4: begin
                            o_res.word.out_byte = b;
                            qc_hdr[15:8] = b;
                        end
                        4'd5: begin
                            o_res.word.out_byte = b;
                            qc_hdr[7:0] = b;
                        end
                        4'd6: o_res.word.out_byte = e_qc[15:8];
                        4'd7: o_res.word.out_byte = e_qc[7:0];
                        default: o_res.word.out_byte = 8'd0;
                    endcase
                    n_qc = qc_hdr;
                    if (e_hp >= HDR_LAST) begin
                        n_phase = (qc_hdr == 16'd0) ? PH_SKIP : PH_NAME;
                        n_hp    = 4'd0;
                    end else begin
                        n_hp = e_hp + 4'd1;
                    end
                    if (i_word.in_last) begin
                        o_res.word.status = (e_hp < HDR_LAST || qc_hdr != 16'd0) ?
                                            dqfar_pkg::ST_TRUNC : dqfar_pkg::ST_OK;
                        n_qc    = e_qd;
                        n_qd    = 16'd0;
                        n_rp    = '0;
                        n_tc    = 4'd0;
                        n_phase = PH_ANAME;
                        o_res.word.out_last = (e_qd == 16'd0);
                    end else begin
                        o_res.word.out_last = (e_hp >= HDR_LAST) && (qc_hdr == 16'd0);
                    end
                end
                PH_SKIP: begin
                    if (i_word.in_last) begin
                        n_qc    = e_qd;
                        n_qd    = 16'd0;
                        n_rp    = '0;
                        n_tc    = 4'd0;
                        n_phase = PH_ANAME;
                    end
                end
                PH_NAME, PH_QTAIL: begin
                    o_res.push          = 1'b1;
                    o_res.word.out_byte = b;
                    if (e_fill >= FILL_FULL) begin
                        o_res.word.status   = dqfar_pkg::ST_OVERFLOW;
                        o_res.word.out_last = (e_qd == 16'd0);
                        if (i_word.in_last) begin
                            n_qc    = e_qd;
                            n_qd    = 16'd0;
                            n_rp    = '0;
                            n_tc    = 4'd0;
                            n_phase = PH_ANAME;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        w_we   = 1'b1;
                        n_fill = e_fill + FW'(1);
                        if (e_phase == PH_NAME) begin
                            if (b == 8'd0) begin
                                ph_after = PH_QTAIL;
                                n_tc     = 4'd0;
                            end
                        end else if (tc_inc >= QTAIL_LEN) begin
                            n_tc     = 4'd0;
                            qd_after = e_qd + 16'd1;
                            ph_after = (qd_after == e_qc) ? PH_SKIP : PH_NAME;
                        end else begin
                            n_tc = tc_inc;
                        end
                        n_qd    = qd_after;
                        n_phase = ph_after;
                        if (i_word.in_last) begin
                            o_res.word.status = (ph_after != PH_SKIP) ?
                                                dqfar_pkg::ST_TRUNC : dqfar_pkg::ST_OK;
                            n_qc    = qd_after;
                            n_qd    = 16'd0;
                            n_rp    = '0;
                            n_tc    = 4'd0;
                            n_phase = PH_ANAME;
                            o_res.word.out_last = (qd_after == 16'd0);
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            o_res.push = 1'b1;
            if (r_phase < PH_ANAME || r_qd >= r_qc) begin
                o_res.word.status = dqfar_pkg::ST_NONE;
            end else if (r_phase == PH_ANAME) begin
                o_res.word.out_byte = r_rd;
                n_rp = r_rp + FW'(1);
                if (r_rd == 8'd0) begin
                    n_phase = PH_ATAIL;
                    n_tc    = 4'd0;
                end
            end else begin
                if (r_tc < TTL_FIRST) begin
                    o_res.word.out_byte = r_rd;
                    n_rp = r_rp + FW'(1);
                end else if (r_tc < RDL_HI) begin
                    o_res.word.out_byte = byte_of(r_ttl, r_tc[1:0]);
                end else if (r_tc == RDL_HI) begin
                    o_res.word.out_byte = 8'd0;
                end else if (r_tc == RDL_LO) begin
                    o_res.word.out_byte = RDLEN_LO;
                end else begin
                    o_res.word.out_byte = byte_of(r_addr, 2'(r_tc - ADDR_BASE));
                end
                if (r_tc >= TAIL_LAST) begin
                    n_tc     = 4'd0;
                    n_phase  = PH_ANAME;
                    qd_after = r_qd + 16'd1;
                    n_qd     = qd_after;
                    o_res.word.out_last = (qd_after >= r_qc);
                end else begin
                    n_tc = r_tc + 4'd1;
                end
            end
        end
    end

    assign w_raddr = n_rp[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hp     <= 4'd0;
            r_opcode <= 4'd0;
            r_qc     <= 16'd0;
            r_qd     <= 16'd0;
            r_tc     <= 4'd0;
            r_fill   <= '0;
            r_rp     <= '0;
            r_ttl    <= dqfar_pkg::TTL_RESET;
            r_addr   <= dqfar_pkg::ADDR_RESET;
        end else begin
            r_phase  <= n_phase;
            r_hp     <= n_hp;
            r_opcode <= n_opcode;
            r_qc     <= n_qc;
            r_qd     <= n_qd;
            r_tc     <= n_tc;
            r_fill   <= n_fill;
            r_rp     <= n_rp;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dqfar_pkg::CFG_TTL:  r_ttl  <= i_cfg_data;
                    dqfar_pkg::CFG_ADDR: r_addr <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // prefetch the entry at the next replay pointer
    always_ff @(posedge i_clk) begin
        if (w_we && i_rst_n) begin
            r_mem[w_waddr] <= b;
        end
        if (w_we && i_rst_n && w_waddr == w_raddr) begin
            r_rd <= b;
        end else begin
            r_rd <= r_mem[w_raddr];
        end
    end
endmodule

### sv/dqfar_outq.sv
module dqfar_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dqfar_pkg::t_rsp_push i_push,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dqfar_pkg::t_rsp_word o_word
);
    localparam logic [1:0] FULL = 2'd2;

    dqfar_pkg::t_rsp_word r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_space = (r_cnt != FULL);
    assign o_word  = r_slot[r_rp];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push.push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push.push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot[r_wp] <= i_push.word;
        end
    end
endmodule

### sv/dns_query_fixed_answer_responder_unit.sv
// channel   dir  payload                          word
// i_req     in   operation, in_byte, in_last      request byte or answer pull
// o_rsp     out  out_byte, out_last, status       response byte or status
// i_cfg_*   in   index 0 answer_ttl, 1 answer_address (32 bits each)
//
// One word per cycle in while i_req.ready is high; o_rsp.valid is high the cycle after an accept that pushes a result.
// The state update and the answer store read fit in the accept cycle;
// the store read address is the next replay pointer, so data waits in a register.
// A two-word output queue holds results; i_req.ready drops when it is full or in reset.
// Synchronous reset clears control and restores both config registers; store unset.
module dns_query_fixed_answer_responder_unit #(
    parameter int STORE_DEPTH = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dqfar_req_if.sink          i_req,
    dqfar_rsp_if.source        o_rsp,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    dqfar_pkg::t_req_word w_req;
    dqfar_pkg::t_rsp_push w_push;
    dqfar_pkg::t_rsp_word w_out;
    logic                 w_space;
    logic                 w_accept;

    assign w_req.operation = i_req.operation;
    assign w_req.in_byte   = i_req.in_byte;
    assign w_req.in_last   = i_req.in_last;
    assign i_req.ready     = w_space && i_rst_n;
    assign w_accept        = i_req.valid && i_req.ready;

    dqfar_core #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_word      (w_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (w_push)
    );

    dqfar_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (w_space),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_word  (w_out)
    );

    assign o_rsp.out_byte = w_out.out_byte;
    assign o_rsp.out_last = w_out.out_last;
    assign o_rsp.status   = w_out.status;
endmodule

### sv/dqfar_checker.sv
`include "dns_query_fixed_answer_responder_unit_defines.svh"

module dqfar_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_req_operation,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [7:0] i_rsp_byte,
    input logic       i_rsp_last,
    input logic [1:0] i_rsp_status
);
    logic [10:0] w_rsp_word;
    logic        w_pull_acc;
    logic        w_none_seen;

    assign w_rsp_word  = {i_rsp_byte, i_rsp_last, i_rsp_status};
    assign w_pull_acc  = i_req_valid && i_req_ready && i_req_operation == dqfar_pkg::OP_PULL;
    assign w_none_seen = i_rsp_valid && i_rsp_status == dqfar_pkg::ST_NONE;

    `DQFAR_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(w_rsp_word))
    `DQFAR_ASSERT_NOW(a_reset_empty, $past(!i_rst_n), !i_rsp_valid)
    `DQFAR_ASSERT_NOW(a_stall_full, !i_req_ready, i_rsp_valid)
    `DQFAR_ASSERT_NEXT(a_pull_answers, w_pull_acc, i_rsp_valid)
    `DQFAR_ASSERT_NOW(a_none_blank, w_none_seen, i_rsp_byte == 8'd0 && !i_rsp_last)
endmodule

bind dns_query_fixed_answer_responder_unit dqfar_checker u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_operation (i_req.operation),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_byte      (o_rsp.out_byte),
    .i_rsp_last      (o_rsp.out_last),
    .i_rsp_status    (o_rsp.status)
);
